### sv/framed_packet_sender_with_ack_assert.svh
// Assertion macros for the framed packet sender checkers.
`ifndef FRAMED_PACKET_SENDER_WITH_ACK_ASSERT_SVH
`define FRAMED_PACKET_SENDER_WITH_ACK_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define FPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define FPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fps_pkg.sv
package fps_pkg;

    localparam int PAYLOAD_BYTES = 32;
    localparam int HEADER_COUNT  = 3;
    localparam int PACKET_BYTES  = 3 + PAYLOAD_BYTES;
    localparam int CNT_W         = $clog2(PACKET_BYTES);
    localparam int IDX_W         = 6;
    localparam int CFG_W         = 24;

    localparam logic [CNT_W-1:0] HDR_LAST_CNT = CNT_W'(HEADER_COUNT - 1);
    localparam logic [CNT_W-1:0] PKT_LAST_CNT = CNT_W'(PACKET_BYTES - 1);
    localparam logic [IDX_W-1:0] PKT_LAST_IDX = IDX_W'(PACKET_BYTES - 1);
    localparam logic [1:0]       REPLY_BYTES  = 2'd3;

    localparam logic [7:0]  HEADER_RST  = 8'h50;
    localparam logic [23:0] ACK_RST     = 24'hAA0500;
    localparam logic [15:0] TIMEOUT_RST = 16'd1500;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_RX     = 2'd1,
        ACT_WRITE  = 2'd2,
        ACT_SUBMIT = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_TX       = 2'd0,
        KIND_ACK      = 2'd1,
        KIND_MISMATCH = 2'd2,
        KIND_TIMEOUT  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_HEADER  = 2'd0,
        REG_ACK     = 2'd1,
        REG_TIMEOUT = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_SET_PENDING,
        OP_STORE,
        OP_RX_SHIFT,
        OP_EMIT_REPLY,
        OP_CNT_CLEAR,
        OP_EMIT_HDR,
        OP_EMIT_DATA,
        OP_START_WAIT,
        OP_WAIT_INC,
        OP_EMIT_TIMEOUT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_ACT_TICK,
        C_ACT_RX,
        C_ACT_WRITE,
        C_NOT_AWAIT,
        C_REPLY_MORE,
        C_AWAIT,
        C_NO_SEND,
        C_HDR_MORE,
        C_PKT_MORE,
        C_WAIT_OVER
    } cond_t;

    typedef enum logic [4:0] {
        ST_FETCH,
        ST_DISP_TICK,
        ST_DISP_RX,
        ST_DISP_WRITE,
        ST_SUBMIT,
        ST_WRITE,
        ST_RX_CHECK,
        ST_RX_SHIFT,
        ST_RX_COUNT,
        ST_RX_REPORT,
        ST_TICK_AWAIT,
        ST_TICK_SEND,
        ST_CNT_CLEAR,
        ST_HDR,
        ST_DATA,
        ST_START_WAIT,
        ST_WAIT_CHECK,
        ST_WAIT_INC,
        ST_TIMEOUT
    } step_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } fps_ctrl_t;

    typedef struct packed {
        logic    item_valid;
        action_t action;
        logic    awaiting;
        logic    reply_more;
        logic    no_send;
        logic    hdr_more;
        logic    pkt_more;
        logic    wait_over;
        logic    out_busy;
    } fps_status_t;

    function automatic fps_ctrl_t ucode_rom(input step_t step);
        fps_ctrl_t w;
        unique case (step)
            ST_FETCH:      w = '{OP_ACCEPT,       C_NO_ITEM,    ST_FETCH};
            ST_DISP_TICK:  w = '{OP_NOP,          C_ACT_TICK,   ST_TICK_AWAIT};
            ST_DISP_RX:    w = '{OP_NOP,          C_ACT_RX,     ST_RX_CHECK};
            ST_DISP_WRITE: w = '{OP_NOP,          C_ACT_WRITE,  ST_WRITE};
            ST_SUBMIT:     w = '{OP_SET_PENDING,  C_ALWAYS,     ST_FETCH};
            ST_WRITE:      w = '{OP_STORE,        C_ALWAYS,     ST_FETCH};
            ST_RX_CHECK:   w = '{OP_NOP,          C_NOT_AWAIT,  ST_FETCH};
            ST_RX_SHIFT:   w = '{OP_RX_SHIFT,     C_NEVER,      ST_FETCH};
            ST_RX_COUNT:   w = '{OP_NOP,          C_REPLY_MORE, ST_FETCH};
            ST_RX_REPORT:  w = '{OP_EMIT_REPLY,   C_ALWAYS,     ST_FETCH};
            ST_TICK_AWAIT: w = '{OP_NOP,          C_AWAIT,      ST_WAIT_CHECK};
            ST_TICK_SEND:  w = '{OP_NOP,          C_NO_SEND,    ST_FETCH};
            ST_CNT_CLEAR:  w = '{OP_CNT_CLEAR,    C_NEVER,      ST_FETCH};
            ST_HDR:        w = '{OP_EMIT_HDR,     C_HDR_MORE,   ST_HDR};
            ST_DATA:       w = '{OP_EMIT_DATA,    C_PKT_MORE,   ST_DATA};
            ST_START_WAIT: w = '{OP_START_WAIT,   C_ALWAYS,     ST_FETCH};
            ST_WAIT_CHECK: w = '{OP_NOP,          C_WAIT_OVER,  ST_TIMEOUT};
            ST_WAIT_INC:   w = '{OP_WAIT_INC,     C_ALWAYS,     ST_FETCH};
            ST_TIMEOUT:    w = '{OP_EMIT_TIMEOUT, C_ALWAYS,     ST_FETCH};
            default:       w = '{OP_NOP,          C_ALWAYS,     ST_FETCH};
        endcase
        return w;
    endfunction

    function automatic logic is_emit(input op_t op);
        logic r;
        case (op) inside
            OP_EMIT_REPLY, OP_EMIT_HDR, OP_EMIT_DATA, OP_EMIT_TIMEOUT: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### sv/fps_if.sv
interface fps_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       busy_req;
    logic [7:0] byte_value;
    logic [5:0] byte_index;

    modport source (output valid, action, busy_req, byte_value, byte_index, input ready);
    modport sink   (input valid, action, busy_req, byte_value, byte_index, output ready);
endinterface

interface fps_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       last;

    modport source (output valid, kind, tx_byte, last, input ready);
    modport sink   (input valid, kind, tx_byte, last, output ready);
endinterface

### sv/fps_seq.sv
module fps_seq
    import fps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  fps_status_t status,
    output fps_ctrl_t   ctrl
);

    step_t     step_reg;
    step_t     step_next;
    fps_ctrl_t word;
    logic      cond_hit;
    logic      hold;

    assign word = ucode_rom(step_reg);
    assign ctrl = word;
    assign hold = is_emit(word.op) && status.out_busy;

    always_comb
    begin
        unique case (word.cond)
            C_NEVER:      cond_hit = 1'b0;
            C_ALWAYS:     cond_hit = 1'b1;
            C_NO_ITEM:    cond_hit = !status.item_valid;
            C_ACT_TICK:   cond_hit = status.action == ACT_TICK;
            C_ACT_RX:     cond_hit = status.action == ACT_RX;
            C_ACT_WRITE:  cond_hit = status.action == ACT_WRITE;
            C_NOT_AWAIT:  cond_hit = !status.awaiting;
            C_REPLY_MORE: cond_hit = status.reply_more;
            C_AWAIT:      cond_hit = status.awaiting;
            C_NO_SEND:    cond_hit = status.no_send;
            C_HDR_MORE:   cond_hit = status.hdr_more;
            C_PKT_MORE:   cond_hit = status.pkt_more;
            C_WAIT_OVER:  cond_hit = status.wait_over;
            default:      cond_hit = 1'b1;
        endcase
    end

    always_comb
    begin
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (cond_hit)
        begin
            step_next = word.target;
        end
        else
        begin
            step_next = step_t'(step_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

### sv/fps_datapath.sv
module fps_datapath
    import fps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    fps_in_if.sink            in_ch,
    fps_out_if.source         out_ch,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  fps_ctrl_t         ctrl,
    output fps_status_t       status
);

    logic [7:0]       header_reg;
    logic [23:0]      ack_reg;
    logic [15:0]      timeout_reg;

    logic             pending_reg,  pending_next;
    logic             awaiting_reg, awaiting_next;
    logic [1:0]       count_reg,    count_next;
    logic [23:0]      shift_reg,    shift_next;
    logic [15:0]      wait_reg,     wait_next;
    logic [CNT_W-1:0] cnt_reg,      cnt_next;

    action_t          act_reg;
    logic             busy_reg;
    logic [7:0]       byte_reg;
    logic [IDX_W-1:0] index_reg;

    logic [7:0]       pkt_mem_reg [PACKET_BYTES];
    logic [7:0]       rd_data_reg;

    logic             out_valid_reg, out_valid_next;
    kind_t            out_kind_reg;
    logic [7:0]       out_tx_reg;
    logic             out_last_reg;

    logic             out_busy;
    logic             emit_go;
    kind_t            emit_kind;
    logic [7:0]       emit_tx;
    logic             emit_last;
    logic             in_fire;
    logic             match;

    assign in_ch.ready    = ctrl.op == OP_ACCEPT;
    assign in_fire        = in_ch.valid && in_ch.ready;
    assign out_busy       = out_valid_reg && !out_ch.ready;
    assign emit_go        = is_emit(ctrl.op) && !out_busy;
    assign match          = shift_reg == ack_reg;

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.kind    = out_kind_reg;
    assign out_ch.tx_byte = out_tx_reg;
    assign out_ch.last    = out_last_reg;

    assign status.item_valid = in_ch.valid;
    assign status.action     = act_reg;
    assign status.awaiting   = awaiting_reg;
    assign status.reply_more = count_reg < REPLY_BYTES;
    assign status.no_send    = !pending_reg || busy_reg;
    assign status.hdr_more   = cnt_reg != HDR_LAST_CNT;
    assign status.pkt_more   = cnt_reg != PKT_LAST_CNT;
    assign status.wait_over  = wait_reg > timeout_reg;
    assign status.out_busy   = out_busy;

    always_comb
    begin
        pending_next  = pending_reg;
        awaiting_next = awaiting_reg;
        count_next    = count_reg;
        shift_next    = shift_reg;
        wait_next     = wait_reg;
        cnt_next      = cnt_reg;
        emit_kind     = KIND_TX;
        emit_tx       = '0;
        emit_last     = 1'b0;
        unique case (ctrl.op)
            OP_SET_PENDING:
            begin
                pending_next = 1'b1;
            end
            OP_RX_SHIFT:
            begin
                shift_next = {shift_reg[15:0], byte_reg};
                count_next = count_reg + 2'd1;
                wait_next  = '0;
            end
            OP_EMIT_REPLY:
            begin
                emit_kind = match ? KIND_ACK : KIND_MISMATCH;
                emit_last = 1'b1;
                if (emit_go)
                begin
                    awaiting_next = 1'b0;
                    count_next    = '0;
                    shift_next    = '0;
                    wait_next     = '0;
                    if (match)
                    begin
                        pending_next = 1'b0;
                    end
                end
            end
            OP_CNT_CLEAR:
            begin
                cnt_next = '0;
            end
            OP_EMIT_HDR:
            begin
                emit_tx = header_reg;
                if (emit_go)
                begin
                    cnt_next = (cnt_reg == HDR_LAST_CNT) ? '0 : cnt_reg + 1'b1;
                end
            end
            OP_EMIT_DATA:
            begin
                emit_tx   = rd_data_reg;
                emit_last = cnt_reg == PKT_LAST_CNT;
                if (emit_go)
                begin
                    cnt_next = (cnt_reg == PKT_LAST_CNT) ? '0 : cnt_reg + 1'b1;
                end
            end
            OP_START_WAIT:
            begin
                awaiting_next = 1'b1;
                count_next    = '0;
                shift_next    = '0;
                wait_next     = '0;
            end
            OP_WAIT_INC:
            begin
                if (wait_reg != '1)
                begin
                    wait_next = wait_reg + 16'd1;
                end
            end
            OP_EMIT_TIMEOUT:
            begin
                emit_kind = KIND_TIMEOUT;
                emit_last = 1'b1;
                if (emit_go)
                begin
                    awaiting_next = 1'b0;
                    count_next    = '0;
                    shift_next    = '0;
                    wait_next     = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (emit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg    <= HEADER_RST;
            ack_reg       <= ACK_RST;
            timeout_reg   <= TIMEOUT_RST;
            pending_reg   <= 1'b0;
            awaiting_reg  <= 1'b0;
            count_reg     <= '0;
            shift_reg     <= '0;
            wait_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_addr))
                    REG_HEADER:  header_reg  <= cfg_wdata[7:0];
                    REG_ACK:     ack_reg     <= cfg_wdata[23:0];
                    REG_TIMEOUT: timeout_reg <= cfg_wdata[15:0];
                    default:
                    begin
                    end
                endcase
            end
            pending_reg   <= pending_next;
            awaiting_reg  <= awaiting_next;
            count_reg     <= count_next;
            shift_reg     <= shift_next;
            wait_reg      <= wait_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg   <= action_t'(in_ch.action);
            busy_reg  <= in_ch.busy_req;
            byte_reg  <= in_ch.byte_value;
            index_reg <= in_ch.byte_index;
        end
        if (emit_go)
        begin
            out_kind_reg <= emit_kind;
            out_tx_reg   <= emit_tx;
            out_last_reg <= emit_last;
        end
    end

    // packet store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_STORE && index_reg <= PKT_LAST_IDX)
        begin
            pkt_mem_reg[index_reg[CNT_W-1:0]] <= byte_reg;
        end
        rd_data_reg <= pkt_mem_reg[cnt_next];
    end

endmodule

### sv/framed_packet_sender_with_ack.sv
// Channel  Dir  Payload                                   Transaction
// in_ch    in   action busy_req byte_value byte_index     valid & ready
// out_ch   out  kind tx_byte last                         valid & ready
// cfg      in   cfg_addr cfg_wdata                        cfg_we
//
// One item at a time, run by a microcoded step sequencer.
// Sending tick: one byte per cycle from the header loop and the store read loop, while
// the output is not stalled. A stalled output holds the sequencer in its step.
// Reset clears control state and sets config registers to their defaults; the store is not cleared.
module framed_packet_sender_with_ack
    import fps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    fps_in_if.sink           in_ch,
    fps_out_if.source        out_ch,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    fps_ctrl_t   ctrl;
    fps_status_t status;

    fps_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    fps_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .ctrl      (ctrl),
        .status    (status)
    );

endmodule

### sv/fps_checker.sv
`include "framed_packet_sender_with_ack_assert.svh"

module fps_checker
    import fps_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_kind,
    input logic [7:0] out_tx_byte,
    input logic       out_last
);

    logic status_out;

    assign status_out = out_valid && out_kind != KIND_TX;

    // status results carry no byte and always close their item
    `FPS_ASSERT_NOW(a_status_zero, status_out, out_tx_byte == 8'd0, "status result with nonzero byte")
    `FPS_ASSERT_NOW(a_status_last, status_out, out_last, "status result not marked last")
    // one item in flight: no new transaction right after one is taken
    `FPS_ASSERT_NEXT(a_in_one_at_a_time, in_valid && in_ready, !in_ready, "input taken back to back")
    `FPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_tx_byte) && $stable(out_last), "stalled result changed")

endmodule

bind framed_packet_sender_with_ack fps_checker u_fps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_kind    (out_ch.kind),
    .out_tx_byte (out_ch.tx_byte),
    .out_last    (out_ch.last)
);
